### rtl/core/bpa_pkg.sv
package bpa_pkg;

  localparam int unsigned PageCountDef  = 65536;
  localparam int unsigned OrderCountDef = 17;
  localparam int unsigned PageShiftDef  = 12;

  localparam int unsigned PgW    = 16;
  localparam int unsigned OrdW   = 5;
  localparam int unsigned AddrW  = 29;
  localparam int unsigned RefW   = 16;
  localparam logic [RefW-1:0] RefMax = '1;

  typedef enum logic [1:0] {
    KIND_ADD_RANGE = 2'd0,
    KIND_ALLOC     = 2'd1,
    KIND_FREE      = 2'd2,
    KIND_ADD_REF   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_NOT_HEAD = 2'd2,
    ST_STILL_REF = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]       kind;
    logic [AddrW-1:0] range_start;
    logic [AddrW-1:0] range_end;
    logic [PgW-1:0]   page_number;
    logic [OrdW-1:0]  block_order;
  } req_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [PgW-1:0]  result_page;
    logic [OrdW-1:0] result_order;
  } rsp_t;

  // Per-page record held in the page memory.
  typedef struct packed {
    logic            head;
    logic [OrdW-1:0] order;
    logic [RefW-1:0] refs;
  } page_rec_t;

  // Ring links held in the link memory.
  typedef struct packed {
    logic [PgW-1:0] next;
    logic [PgW-1:0] prev;
  } link_rec_t;

endpackage

### rtl/core/buddy_page_allocator.sv
// Channel | Direction | Payload | Handshake
// request | in        | req_t   | req_valid_i / req_ready_o
// result  | out       | rsp_t   | rsp_valid_o / rsp_ready_i
//
// One item at a time; memory read data arrives in the cycle after the address.
// add_ref and a refused free read and check the page record; add_range runs doubling tests,
// a read and a check per block and a ring insert for a new block; alloc scans the orders,
// unlinks and splits; free checks, merges and pushes. After reset a clearing pass writes
// every page record, with the request side not ready. A result waits in the output register;
// the next request is taken after it.
module buddy_page_allocator import bpa_pkg::*; #(
  parameter int unsigned PAGE_COUNT  = PageCountDef,
  parameter int unsigned ORDER_COUNT = OrderCountDef,
  parameter int unsigned PAGE_SHIFT  = PageShiftDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  req_t req_i,
  output logic rsp_valid_o,
  input  logic rsp_ready_i,
  output rsp_t rsp_o
);

  localparam int unsigned PIW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int unsigned OIW = (ORDER_COUNT > 1) ? $clog2(ORDER_COUNT) : 1;
  localparam int unsigned SW  = PIW + 2;   // page values up to and past PAGE_COUNT
  localparam int unsigned CW  = PIW + 1;
  localparam logic [SW-1:0] PageLim = SW'(PAGE_COUNT);
  localparam logic [OrdW-1:0] TopOrd = OrdW'(ORDER_COUNT - 1);

  typedef enum logic [5:0] {
    S_CLEAR, S_IDLE,
    S_AR_LOOP, S_AR_RD, S_AR_CHK,
    S_AL_SCAN, S_AL_RD, S_AL_POP, S_AL_SPL, S_AL_SRD, S_AL_SCHK, S_AL_FIN,
    S_FR_RD, S_FR_CHK, S_FR_BRD, S_FR_BCHK, S_FR_HIWR, S_FR_PUSH,
    S_AF_RD, S_AF_CHK,
    S_RM_RD, S_RM_WAIT, S_RM_Q, S_RM_N,
    S_IN_RD, S_IN_WAIT, S_IN_T, S_IN_H,
    S_OUT
  } st_e;

  st_e st_q, st_d;
  st_e ret_q, ret_d;

  // Page memory and link memory ports.
  logic            pw_we;
  logic [PIW-1:0]  pw_a, pr_a;
  page_rec_t       pw_d, pr_d;
  logic            lw_we;
  logic [PIW-1:0]  lw_a, lr_a;
  link_rec_t       lw_d, lr_d;

  bpa_ram #(.Width($bits(page_rec_t)), .Depth(PAGE_COUNT)) u_page_ram (
    .clk_i, .we_i(pw_we), .waddr_i(pw_a), .wdata_i(pw_d),
    .raddr_i(pr_a), .rdata_o(pr_d));
  bpa_ram #(.Width($bits(link_rec_t)), .Depth(PAGE_COUNT)) u_link_ram (
    .clk_i, .we_i(lw_we), .waddr_i(lw_a), .wdata_i(lw_d),
    .raddr_i(lr_a), .rdata_o(lr_d));

  logic [PIW-1:0] head_q [ORDER_COUNT];
  logic [CW-1:0]  cnt_q  [ORDER_COUNT];
  logic [PIW-1:0] head_d [ORDER_COUNT];
  logic [CW-1:0]  cnt_d  [ORDER_COUNT];

  req_t            req_q, req_d;
  rsp_t            rsp_q, rsp_d;
  logic [SW-1:0]   s_q, s_d, e_q, e_d;
  logic [OrdW-1:0] k_q, k_d, o_q, o_d;
  logic [PIW-1:0]  p_q, p_d, b_q, b_d;
  logic [PIW-1:0]  t_q, t_d;           // scratch page (tail, neighbor)
  link_rec_t       lk_q, lk_d;         // links of the page being unlinked
  page_rec_t       rec_q, rec_d;
  logic [OIW-1:0]  lo_q, lo_d;         // list order for ring operations
  logic [PIW-1:0]  lp_q, lp_d;         // page for ring operations
  logic [PIW-1:0]  clr_q, clr_d;

  // Greedy block size for a range step: one doubling test per cycle.
  logic [SW:0] two_k, s_plus;
  logic        can_grow;
  logic [SW+1:0] rs_pages;
  logic [SW-1:0] e_pages;
  logic [SW:0]   sb_full;
  logic [OrdW:0] ord_wide;
  logic [PIW:0]  buddy;

  always_comb begin
    two_k    = (SW+1)'(2) << k_q;
    s_plus   = {1'b0, s_q} + two_k;
    can_grow = ({27'b0, k_q} + 32'd1 < 32'(ORDER_COUNT)) &&
               ((({1'b0, s_q}) & (two_k - 1'b1)) == '0) &&
               (s_plus <= {1'b0, e_q});
    rs_pages = (SW+2)'((33'(req_q.range_start) + 33'((64'd1 << PAGE_SHIFT) - 1))
                       >> PAGE_SHIFT);
    e_pages  = 33'(req_q.range_end) >> PAGE_SHIFT > 33'(PAGE_COUNT)
               ? PageLim : SW'(33'(req_q.range_end) >> PAGE_SHIFT);
    sb_full  = {1'b0, s_q} + ((SW+1)'(1) << k_q);
    ord_wide = {1'b0, o_q};
    buddy    = (PIW+1)'(p_q) ^ ((PIW+1)'(1) << o_q);
  end

  always_comb begin
    st_d = st_q; ret_d = ret_q;
    req_d = req_q; rsp_d = rsp_q;
    s_d = s_q; e_d = e_q; k_d = k_q; o_d = o_q; p_d = p_q; b_d = b_q;
    t_d = t_q; lk_d = lk_q; rec_d = rec_q; lo_d = lo_q; lp_d = lp_q;
    clr_d = clr_q;
    head_d = head_q; cnt_d = cnt_q;
    pw_we = 1'b0; pw_a = '0; pw_d = '0; pr_a = '0;
    lw_we = 1'b0; lw_a = '0; lw_d = '0; lr_a = '0;
    req_ready_o = 1'b0;
    unique case (st_q)
      S_CLEAR: begin
        pw_we = 1'b1; pw_a = clr_q;
        clr_d = clr_q + 1'b1;
        if (clr_q == PIW'(PAGE_COUNT - 1)) st_d = S_IDLE;
      end
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          req_d = req_i;
          rsp_d = '0;
          unique case (kind_e'(req_i.kind))
            KIND_ADD_RANGE: st_d = S_AR_LOOP;
            KIND_ALLOC: begin
              if (req_i.block_order > TopOrd) begin
                rsp_d.status = ST_NO_FREE;
                st_d = S_OUT;
              end else begin
                o_d = req_i.block_order;
                st_d = S_AL_SCAN;
              end
            end
            KIND_FREE, KIND_ADD_REF: begin
              rsp_d.result_page  = req_i.page_number;
              rsp_d.result_order = (kind_e'(req_i.kind) == KIND_FREE)
                                   ? req_i.block_order : '0;
              if (32'(req_i.page_number) >= 32'(PAGE_COUNT)) begin
                rsp_d.status = ST_NOT_HEAD;
                st_d = S_OUT;
              end else begin
                p_d = PIW'(req_i.page_number);
                st_d = (kind_e'(req_i.kind) == KIND_FREE) ? S_FR_RD : S_AF_RD;
              end
            end
            default: st_d = S_OUT;
          endcase
          s_d = '0; e_d = '0; k_d = '0;
        end
      end
      // ---------------- add_range
      S_AR_LOOP: begin
        // First entry loads the page bounds.
        if (rsp_q.result_page == '0 && k_q == '0 && s_q == '0 && e_q == '0) begin
          s_d = SW'(rs_pages);
          e_d = e_pages;
          rsp_d.result_page = PgW'(1);   // marks bounds as loaded
          if (rs_pages >= (SW+2)'(e_pages)) begin
            rsp_d = '0; st_d = S_OUT;
          end
        end else if (s_q >= e_q) begin
          rsp_d = '0; st_d = S_OUT;
        end else if (can_grow) begin
          k_d = k_q + 1'b1;
        end else begin
          st_d = S_AR_RD;
        end
      end
      S_AR_RD: begin
        pr_a = PIW'(s_q);
        st_d = S_AR_CHK;
      end
      S_AR_CHK: begin
        s_d = SW'(sb_full);
        k_d = '0;
        if (!pr_d.head) begin
          pw_we = 1'b1; pw_a = PIW'(s_q);
          pw_d = '{head: 1'b1, order: k_q, refs: pr_d.refs};
          lo_d = OIW'(k_q); lp_d = PIW'(s_q);
          ret_d = S_AR_LOOP;
          st_d = S_IN_RD;
        end else begin
          st_d = S_AR_LOOP;
        end
      end
      // ---------------- alloc
      S_AL_SCAN: begin
        if (32'(o_q) >= 32'(ORDER_COUNT)) begin
          rsp_d = '0; rsp_d.status = ST_NO_FREE;
          st_d = S_OUT;
        end else if (cnt_q[OIW'(o_q)] == '0) begin
          o_d = o_q + 1'b1;
        end else begin
          p_d = head_q[OIW'(o_q)];
          lo_d = OIW'(o_q); lp_d = head_q[OIW'(o_q)];
          ret_d = S_AL_RD;
          st_d = S_RM_RD;
        end
      end
      S_AL_RD: begin
        pr_a = p_q;
        st_d = S_AL_POP;
      end
      S_AL_POP: begin
        rec_d = pr_d;
        if (pr_d.refs != RefMax) rec_d.refs = pr_d.refs + 1'b1;
        st_d = S_AL_SPL;
      end
      S_AL_SPL: begin
        if (o_q == req_q.block_order) begin
          st_d = S_AL_FIN;
        end else begin
          o_d = o_q - 1'b1;
          b_d = p_q ^ (PIW'(1) << (o_q - 1'b1));
          st_d = S_AL_SRD;
        end
      end
      S_AL_SRD: begin
        pr_a = b_q;
        st_d = S_AL_SCHK;
      end
      S_AL_SCHK: begin
        if (!pr_d.head) begin
          pw_we = 1'b1; pw_a = b_q;
          pw_d = '{head: 1'b1, order: o_q, refs: pr_d.refs};
          lo_d = OIW'(o_q); lp_d = b_q;
          ret_d = S_AL_SPL;
          st_d = S_IN_RD;
        end else begin
          st_d = S_AL_SPL;
        end
      end
      S_AL_FIN: begin
        pw_we = 1'b1; pw_a = p_q;
        pw_d = rec_q; pw_d.order = req_q.block_order;
        rsp_d.status = ST_DONE;
        rsp_d.result_page = PgW'(p_q);
        rsp_d.result_order = req_q.block_order;
        st_d = S_OUT;
      end
      // ---------------- free
      S_FR_RD: begin
        pr_a = p_q;
        st_d = S_FR_CHK;
      end
      S_FR_CHK: begin
        if (!pr_d.head || pr_d.order != req_q.block_order || pr_d.refs == '0) begin
          rsp_d.status = ST_NOT_HEAD;
          st_d = S_OUT;
        end else begin
          pw_we = 1'b1; pw_a = p_q;
          pw_d = pr_d; pw_d.refs = pr_d.refs - 1'b1;
          if (pr_d.refs != RefW'(1)) begin
            rsp_d.status = ST_STILL_REF;
            st_d = S_OUT;
          end else begin
            o_d = req_q.block_order;
            st_d = S_FR_BRD;
          end
        end
      end
      S_FR_BRD: begin
        if (ord_wide + 1'b1 >= (OrdW+1)'(ORDER_COUNT) ||
            buddy >= (PIW+1)'(PAGE_COUNT)) begin
          st_d = S_FR_PUSH;
        end else begin
          b_d = PIW'(buddy);
          pr_a = PIW'(buddy);
          st_d = S_FR_BCHK;
        end
      end
      S_FR_BCHK: begin
        if (!pr_d.head || pr_d.order != o_q || pr_d.refs != '0) begin
          st_d = S_FR_PUSH;
        end else begin
          lo_d = OIW'(o_q); lp_d = b_q;
          ret_d = S_FR_HIWR;
          st_d = S_RM_RD;
        end
      end
      S_FR_HIWR: begin
        pw_we = 1'b1;
        pw_a = (b_q > p_q) ? b_q : p_q;
        pw_d = '0;   // head and order cleared; this page's count is already zero
        p_d = (b_q < p_q) ? b_q : p_q;
        o_d = o_q + 1'b1;
        st_d = S_FR_BRD;
      end
      S_FR_PUSH: begin
        pw_we = 1'b1; pw_a = p_q;
        pw_d = '{head: 1'b1, order: o_q, refs: '0};
        lo_d = OIW'(o_q); lp_d = p_q;
        rsp_d.status = ST_DONE;
        rsp_d.result_page = PgW'(p_q);
        rsp_d.result_order = o_q;
        ret_d = S_OUT;
        st_d = S_IN_RD;
      end
      // ---------------- add_ref
      S_AF_RD: begin
        pr_a = p_q;
        st_d = S_AF_CHK;
      end
      S_AF_CHK: begin
        if (!pr_d.head || pr_d.refs == '0) begin
          rsp_d.status = ST_NOT_HEAD;
        end else begin
          pw_we = 1'b1; pw_a = p_q;
          pw_d = pr_d;
          if (pr_d.refs != RefMax) pw_d.refs = pr_d.refs + 1'b1;
        end
        st_d = S_OUT;
      end
      // ---------------- ring remove of lp from list lo
      S_RM_RD: begin
        lr_a = lp_q;
        st_d = S_RM_WAIT;
      end
      S_RM_WAIT: begin
        lk_d = lr_d;
        if (cnt_q[lo_q] > CW'(1)) begin
          st_d = S_RM_Q;
          if (head_q[lo_q] == lp_q) head_d[lo_q] = lr_d.next;
        end else begin
          st_d = ret_q;
        end
        if (cnt_q[lo_q] != '0) cnt_d[lo_q] = cnt_q[lo_q] - 1'b1;
      end
      S_RM_Q: begin
        // Read q's links to rewrite next only.
        lr_a = lk_q.prev;
        st_d = S_RM_N;
      end
      S_RM_N: begin
        if (lk_q.prev == lk_q.next) begin
          // Two-entry ring: the survivor points at itself.
          lw_we = 1'b1; lw_a = lk_q.next;
          lw_d = '{next: lk_q.next, prev: lk_q.next};
          st_d = ret_q;
        end else begin
          lw_we = 1'b1; lw_a = lk_q.prev;
          lw_d = '{next: lk_q.next, prev: lr_d.prev};
          lr_a = lk_q.next;
          lp_d = lk_q.next;
          st_d = S_IN_H;   // reuse: finish next's prev below
          ret_d = ret_q;
          t_d = lk_q.prev;
          rec_d.head = 1'b0;   // marks remove mode in S_IN_H
        end
      end
      // ---------------- ring insert of lp into list lo
      S_IN_RD: begin
        rec_d.head = 1'b1;
        if (cnt_q[lo_q] == '0) begin
          lw_we = 1'b1; lw_a = lp_q;
          lw_d = '{next: lp_q, prev: lp_q};
          head_d[lo_q] = lp_q;
          cnt_d[lo_q] = CW'(1);
          st_d = ret_q;
        end else begin
          lr_a = head_q[lo_q];
          st_d = S_IN_WAIT;
        end
      end
      S_IN_WAIT: begin
        // lr_d: links of the head h; tail t = h.prev.
        t_d = lr_d.prev;
        lk_d = lr_d;
        if (lr_d.prev == head_q[lo_q]) begin
          // One-entry ring: head is also tail.
          lw_we = 1'b1; lw_a = head_q[lo_q];
          lw_d = '{next: lp_q, prev: lp_q};
          st_d = S_IN_T;
          b_d = head_q[lo_q];
        end else begin
          lw_we = 1'b1; lw_a = head_q[lo_q];
          lw_d = '{next: lr_d.next, prev: lp_q};
          lr_a = lr_d.prev;
          st_d = S_IN_H;
        end
      end
      S_IN_H: begin
        if (rec_q.head) begin
          // lr_d: links of the tail; point its next at the new page.
          lw_we = 1'b1; lw_a = t_q;
          lw_d = '{next: lp_q, prev: lr_d.prev};
          b_d = head_q[lo_q];
          st_d = S_IN_T;
        end else begin
          // Remove: next page's prev becomes q.
          lw_we = 1'b1; lw_a = lp_q;
          lw_d = '{next: lr_d.next, prev: t_q};
          st_d = ret_q;
        end
      end
      S_IN_T: begin
        lw_we = 1'b1; lw_a = lp_q;
        lw_d = '{next: b_q, prev: t_q};
        head_d[lo_q] = lp_q;
        cnt_d[lo_q] = cnt_q[lo_q] + 1'b1;
        st_d = ret_q;
      end
      S_OUT: begin
        if (rsp_ready_i) st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= S_CLEAR;
      ret_q <= S_IDLE;
      clr_q <= '0;
      for (int i = 0; i < ORDER_COUNT; i++) cnt_q[i] <= '0;
    end else begin
      st_q  <= st_d;
      ret_q <= ret_d;
      clr_q <= clr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d; rsp_q <= rsp_d;
    s_q <= s_d; e_q <= e_d; k_q <= k_d; o_q <= o_d; p_q <= p_d; b_q <= b_d;
    t_q <= t_d; lk_q <= lk_d; rec_q <= rec_d; lo_q <= lo_d; lp_q <= lp_d;
    head_q <= head_d;
  end

  assign rsp_valid_o = (st_q == S_OUT);
  assign rsp_o = rsp_q;

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_ready_o |-> !rsp_valid_o)
    else $error("request taken while a result is pending");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("result dropped before transfer");
  a_single_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_IDLE) |-> !pw_we && !lw_we)
    else $error("memory written while idle");

endmodule

### rtl/core/bpa_ram.sv
module bpa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top import bpa_pkg::*;;

  localparam int unsigned NumPages  = 65536;
  localparam int unsigned NumOrders = 17;
  localparam int unsigned RandItems = 530;
  localparam int unsigned CycleLimit = 1500000;

  typedef struct {
    req_t req;
    bit   wait_drain;
  } pend_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  always #5 clk_i = ~clk_i;

  buddy_page_allocator u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid),
    .req_ready_o(req_ready),
    .req_i      (req),
    .rsp_valid_o(rsp_valid),
    .rsp_ready_i(rsp_ready),
    .rsp_o      (rsp)
  );

  // Allocator state as seen by the predictor.
  bit              pg_head[NumPages];
  bit [OrdW-1:0]   pg_ord[NumPages];
  bit [RefW-1:0]   pg_refs[NumPages];
  bit [PgW-1:0]    pg_next[NumPages];
  bit [PgW-1:0]    pg_prev[NumPages];
  bit [PgW-1:0]    lst_head[NumOrders];
  int unsigned     lst_cnt[NumOrders];

  pend_item_t pend_q[$];
  rsp_t       alloc_rsp_q[$];
  int unsigned sent_cnt = 0;
  int unsigned rcvd_cnt = 0;
  int unsigned total_items = 0;
  int unsigned errors = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned cycles = 0;

  function automatic void ring_insert(int unsigned o, bit [PgW-1:0] p);
    bit [PgW-1:0] h, t;
    if (lst_cnt[o] == 0) begin
      pg_next[p] = p;
      pg_prev[p] = p;
    end else begin
      h = lst_head[o];
      t = pg_prev[h];
      pg_next[p] = h;
      pg_prev[p] = t;
      pg_next[t] = p;
      pg_prev[h] = p;
    end
    lst_head[o] = p;
    lst_cnt[o]++;
  endfunction

  function automatic void ring_remove(int unsigned o, bit [PgW-1:0] p);
    bit [PgW-1:0] n, q;
    if (lst_cnt[o] == 0) return;
    if (lst_cnt[o] > 1) begin
      n = pg_next[p];
      q = pg_prev[p];
      pg_next[q] = n;
      pg_prev[n] = q;
      if (lst_head[o] == p) lst_head[o] = n;
    end
    lst_cnt[o]--;
  endfunction

  function automatic void push_block(bit [PgW-1:0] p, int unsigned o);
    pg_head[p] = 1'b1;
    pg_ord[p] = o[OrdW-1:0];
    ring_insert(o, p);
  endfunction

  function automatic rsp_t predict_alloc(req_t r);
    longint unsigned s, e;
    int unsigned k, i, o, ord;
    bit [PgW-1:0] h, b, p, hi;
    ord = r.block_order;
    case (kind_e'(r.kind))
      KIND_ADD_RANGE: begin
        s = (longint'(r.range_start) + 4095) >> PageShiftDef;
        e = longint'(r.range_end) >> PageShiftDef;
        if (e > NumPages) e = NumPages;
        while (s < e) begin
          k = 0;
          while (k + 1 < NumOrders && (s & ((longint'(2) << k) - 1)) == 0 &&
                 s + (longint'(2) << k) <= e)
            k++;
          if (!pg_head[s]) push_block(s[PgW-1:0], k);
          s += longint'(1) << k;
        end
        return '{ST_DONE, '0, '0};
      end
      KIND_ALLOC: begin
        if (ord >= NumOrders) return '{ST_NO_FREE, '0, '0};
        for (i = ord; i < NumOrders; i++) begin
          if (lst_cnt[i] == 0) continue;
          h = lst_head[i];
          ring_remove(i, h);
          if (pg_refs[h] != RefMax) pg_refs[h]++;
          for (o = i; o > ord; o--) begin
            b = h ^ (PgW'(1) << (o - 1));
            if (!pg_head[b]) push_block(b, o - 1);
          end
          pg_ord[h] = ord[OrdW-1:0];
          return '{ST_DONE, h, ord[OrdW-1:0]};
        end
        return '{ST_NO_FREE, '0, '0};
      end
      KIND_FREE: begin
        p = r.page_number;
        if (!pg_head[p] || pg_ord[p] != r.block_order || pg_refs[p] == 0)
          return '{ST_NOT_HEAD, p, r.block_order};
        pg_refs[p]--;
        if (pg_refs[p] != 0) return '{ST_STILL_REF, p, r.block_order};
        o = ord;
        while (o + 1 < NumOrders) begin
          b = p ^ (PgW'(1) << o);
          if (!pg_head[b] || pg_ord[b] != o || pg_refs[b] != 0) break;
          ring_remove(o, b);
          hi = (b > p) ? b : p;
          p = (b < p) ? b : p;
          pg_head[hi] = 1'b0;
          pg_ord[hi] = '0;
          o++;
        end
        push_block(p, o);
        return '{ST_DONE, p, o[OrdW-1:0]};
      end
      default: begin
        p = r.page_number;
        if (!pg_head[p] || pg_refs[p] == 0) return '{ST_NOT_HEAD, p, '0};
        if (pg_refs[p] != RefMax) pg_refs[p]++;
        return '{ST_DONE, p, '0};
      end
    endcase
  endfunction

  function automatic rsp_t queue_item(kind_e kind, int unsigned rs, int unsigned re,
                                      int unsigned pg, int unsigned ord, bit drain);
    pend_item_t it;
    rsp_t r;
    it.req = '{kind, rs[AddrW-1:0], re[AddrW-1:0], pg[PgW-1:0], ord[OrdW-1:0]};
    it.wait_drain = drain;
    r = predict_alloc(it.req);
    pend_q.push_back(it);
    alloc_rsp_q.push_back(r);
    total_items++;
    return r;
  endfunction

  function automatic bit chance(int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic int unsigned phase_of(int unsigned n);
    return (n / 50) % 4;
  endfunction

  // Request driver.
  always @(posedge clk_i) begin
    logic fire;
    bit offer;
    int unsigned sent_now, idle_pct;
    if (rst_ni) begin
      fire = req_valid && req_ready;
      sent_now = sent_cnt + fire;
      if (fire) sent_cnt <= sent_now;
      if (!req_valid || fire) begin
        offer = 1'b0;
        idle_pct = (phase_of(sent_now) == 1) ? 69 : (phase_of(sent_now) == 3) ? 34 : 0;
        if (pend_q.size() > 0 && !(pend_q[0].wait_drain && rcvd_cnt != sent_now))
          offer = !chance(idle_pct);
        if (offer) begin
          req <= pend_q[0].req;
          void'(pend_q.pop_front());
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, so the block backs up and stalls its request side.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && sent_cnt >= 150) begin
      hold_left <= 600;
      hold_done <= 1'b1;
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    rsp_t exp_rsp;
    int unsigned stall_pct;
    if (rst_ni) begin
      if (rsp_valid && rsp_ready) begin
        rcvd_cnt <= rcvd_cnt + 1;
        if (alloc_rsp_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result transfer: %p", rsp);
        end else begin
          exp_rsp = alloc_rsp_q.pop_front();
          if (rsp.status !== exp_rsp.status || rsp.result_page !== exp_rsp.result_page ||
              rsp.result_order !== exp_rsp.result_order) begin
            errors++;
            if (errors <= 10)
              $display("result %0d mismatch: expected %p, got %p", rcvd_cnt, exp_rsp, rsp);
          end
        end
      end
      stall_pct = (phase_of(rcvd_cnt) == 2) ? 69 : (phase_of(rcvd_cnt) == 3) ? 34 : 0;
      rsp_ready <= (hold_left == 0) && !chance(stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    int unsigned cursor, len, n, idx, ord, pg;
    int unsigned live_pg[$], live_ord[$];
    rsp_t r;

    // Directed part: the whole array as one block, split and merge, refusals.
    void'(queue_item(KIND_ADD_RANGE, 0, 32'h1000_0000, 0, 0, 0));
    void'(queue_item(KIND_ADD_RANGE, 0, 32'h1000_0000, 0, 0, 0));
    void'(queue_item(KIND_ALLOC, 0, 0, 0, 16, 0));
    void'(queue_item(KIND_ALLOC, 0, 0, 0, 0, 0));
    void'(queue_item(KIND_ADD_REF, 0, 0, 0, 0, 0));
    void'(queue_item(KIND_FREE, 0, 0, 0, 16, 0));
    void'(queue_item(KIND_FREE, 0, 0, 0, 5, 0));
    void'(queue_item(KIND_FREE, 0, 0, 0, 16, 0));
    void'(queue_item(KIND_FREE, 0, 0, 0, 16, 0));
    void'(queue_item(KIND_ADD_REF, 0, 0, 0, 0, 0));
    void'(queue_item(KIND_ALLOC, 0, 0, 0, 0, 0));
    void'(queue_item(KIND_FREE, 0, 0, 0, 0, 0));
    void'(queue_item(KIND_ALLOC, 0, 0, 0, 17, 0));
    void'(queue_item(KIND_ALLOC, 0, 0, 0, 31, 0));
    void'(queue_item(KIND_ALLOC, 0, 0, 0, 16, 0));
    // Ranges at the top of the address space, and empty ones.
    void'(queue_item(KIND_ADD_RANGE, 32'h0FFF_E000, 32'h1000_0000, 0, 0, 0));
    void'(queue_item(KIND_ADD_RANGE, 32'h0FFF_FFFF, 0, 0, 0, 0));
    void'(queue_item(KIND_ADD_RANGE, 32'h1000_0000, 32'h1000_0000, 0, 0, 0));
    void'(queue_item(KIND_FREE, 0, 0, 16'hFFFF, 0, 0));
    void'(queue_item(KIND_ADD_REF, 0, 0, 16'hFFFF, 0, 0));
    void'(queue_item(KIND_ALLOC, 0, 0, 0, 1, 0));
    void'(queue_item(KIND_FREE, 0, 0, 16'hFFFE, 1, 0));

    // Random part. New ranges never overlap one another, so the rings stay sound.
    cursor = 8;
    for (int unsigned it = 0; it < RandItems; it++) begin
      n = $urandom_range(0, 99);
      if (n < 10 && cursor < 60000) begin
        len = $urandom_range(1, 600);
        void'(queue_item(KIND_ADD_RANGE, cursor * 4096 + $urandom_range(0, 4095),
                         (cursor + len) * 4096 + $urandom_range(0, 4095), 0, 0,
                         it == 320));
        cursor += len + 2;
      end else if (n < 50 || live_pg.size() == 0) begin
        ord = chance(10) ? $urandom_range(0, 16) : $urandom_range(0, 3);
        r = queue_item(KIND_ALLOC, 0, 0, 0, ord, it == 320);
        if (r.status == ST_DONE) begin
          live_pg.push_back(r.result_page);
          live_ord.push_back(r.result_order);
        end
      end else if (n < 85) begin
        idx = $urandom_range(0, live_pg.size() - 1);
        r = queue_item(KIND_FREE, 0, 0, live_pg[idx], live_ord[idx], it == 320);
        if (r.status == ST_DONE) begin
          live_pg.delete(idx);
          live_ord.delete(idx);
        end
      end else if (n < 95) begin
        idx = $urandom_range(0, live_pg.size() - 1);
        void'(queue_item(KIND_ADD_REF, 0, 0, live_pg[idx], 0, it == 320));
      end else begin
        // Noise: random pages and orders, and empty ranges with random bits.
        pg = $urandom_range(0, 65535);
        void'(queue_item(kind_e'($urandom_range(0, 3)), $urandom_range(0, 32'h1FFF_FFFF),
                         0, pg, $urandom_range(0, 31), it == 320));
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (sent_cnt == total_items && rcvd_cnt == total_items);
    repeat (100) @(posedge clk_i);
    if (alloc_rsp_q.size() != 0) errors++;
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/bpa_pkg.sv
rtl/core/bpa_ram.sv
rtl/core/buddy_page_allocator.sv
verif/tb_top.sv
